/* rtl/core/plist_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_pkg: shared codes for the positional list engine
// Command codes, status codes and field widths used across the list core.
// ----------------------------------------------------------------------------
package plist_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned CMD_W    = 3;
   localparam int unsigned POS_W    = 9;
   localparam int unsigned STATUS_W = 2;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_APPEND = 3'd0;
   localparam cmd_type CMD_INSERT = 3'd1;
   localparam cmd_type CMD_REMOVE = 3'd2;
   localparam cmd_type CMD_READ   = 3'd3;
   localparam cmd_type CMD_CLEAR  = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;
   localparam status_type ST_EMPTY = 2'd3;

endpackage
`default_nettype wire

/* rtl/core/plist_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module plist_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/positional_list_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values in one RAM
// Append, insert, remove, read and clear by position, with a live count.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on the rsp_ ports for exactly one cycle, marked by rsp_valid, and
// the receiver cannot hold it off. The entries live in one synchronous RAM
// with one write and one read port, so entries are moved one at a time.
// Append, clear, undefined codes, any refused command, insert at or past
// the count and removal of the last entry are answered straight from idle;
// a read passes through S_READ, an insert below the count through
// S_SHIFT_UP and S_PLACE, and a remove below count - 1 through S_SHIFT_DN.
// Busy stays low in the cycle the strobe is shown, so the next command can
// follow right away. The RAM is never cleared; only entries below the count
// are ever used.
// ----------------------------------------------------------------------------
module positional_list_engine
   import plist_pkg::*;
#(
   parameter int unsigned CAPACITY = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [CMD_W-1:0]     req_command,
   input  wire logic [POS_W-1:0]     req_position,
   input  wire logic signed [31:0]   req_item_value,
   // result channel
   output logic                      rsp_valid,
   output logic signed [31:0]        rsp_read_value,
   output logic [POS_W-1:0]          rsp_entry_count,
   output logic [STATUS_W-1:0]       rsp_status
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SHIFT_UP = 3'd1;
   localparam logic [2:0] S_PLACE    = 3'd2;
   localparam logic [2:0] S_SHIFT_DN = 3'd3;
   localparam logic [2:0] S_READ     = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       lim_ff, lim_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [DATA_W-1:0]   val_ff, val_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_read_value_ff, rsp_read_value_in;
   logic [POS_W-1:0]    rsp_entry_count_ff, rsp_entry_count_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic                ram_we;
   logic [AW-1:0]       ram_wa;
   logic [DATA_W-1:0]   ram_wd;
   logic [AW-1:0]       ram_ra;
   logic [DATA_W-1:0]   ram_rd;

   logic                accept;
   logic [XW-1:0]       pos_x;
   logic [XW-1:0]       cnt_x;
   logic [AW-1:0]       req_pos_a;

   assign accept    = start && (state_ff == S_IDLE);
   assign pos_x     = XW'(req_position);
   assign cnt_x     = XW'(count_ff);
   assign req_pos_a = AW'(req_position);

   plist_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      wr_ptr_in          = wr_ptr_ff;
      lim_in             = lim_ff;
      pos_in             = pos_ff;
      val_in             = val_ff;
      rsp_valid_in       = 1'b0;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      rsp_status_in      = rsp_status_ff;
      ram_we             = 1'b0;
      ram_wa             = wr_ptr_ff;
      ram_wd             = ram_rd;
      ram_ra             = wr_ptr_ff - AW'(2);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_read_value_in = '0;
               rsp_status_in     = ST_OK;
               case (req_command)
                  CMD_APPEND, CMD_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        // refuse: list is full
                        rsp_status_in = ST_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        count_in = count_ff + CW'(1);
                        if (req_command == CMD_APPEND || pos_x >= cnt_x) begin
                           // write straight to the tail
                           ram_we       = 1'b1;
                           ram_wa       = AW'(count_ff);
                           ram_wd       = req_item_value;
                           rsp_valid_in = 1'b1;
                        end else begin
                           // open a gap: move entries up from the tail
                           ram_ra    = AW'(count_ff - CW'(1));
                           wr_ptr_in = AW'(count_ff);
                           lim_in    = req_pos_a + AW'(1);
                           pos_in    = req_pos_a;
                           val_in    = req_item_value;
                           state_in  = S_SHIFT_UP;
                        end
                     end
                  end
                  CMD_REMOVE, CMD_READ: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else if (pos_x >= cnt_x) begin
                        rsp_status_in = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else if (req_command == CMD_READ) begin
                        ram_ra   = req_pos_a;
                        state_in = S_READ;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (pos_x == cnt_x - XW'(1)) begin
                           // last entry: just drop it
                           rsp_valid_in = 1'b1;
                        end else begin
                           // close the gap: move entries down
                           ram_ra    = req_pos_a + AW'(1);
                           wr_ptr_in = req_pos_a;
                           lim_in    = AW'(count_ff - CW'(2));
                           state_in  = S_SHIFT_DN;
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               rsp_entry_count_in = POS_W'(count_in);
            end
         end

         S_SHIFT_UP: begin
            // write the entry read last cycle one place up, read the next
            ram_we = 1'b1;
            ram_ra = wr_ptr_ff - AW'(2);
            if (wr_ptr_ff == lim_ff) begin
               state_in = S_PLACE;
            end else begin
               wr_ptr_in = wr_ptr_ff - AW'(1);
            end
         end

         S_PLACE: begin
            ram_we       = 1'b1;
            ram_wa       = pos_ff;
            ram_wd       = val_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         S_SHIFT_DN: begin
            // write the entry read last cycle one place down, read ahead
            ram_we = 1'b1;
            ram_ra = wr_ptr_ff + AW'(2);
            if (wr_ptr_ff == lim_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               wr_ptr_in = wr_ptr_ff + AW'(1);
            end
         end

         S_READ: begin
            rsp_read_value_in = ram_rd;
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      wr_ptr_ff          <= wr_ptr_in;
      lim_ff             <= lim_in;
      pos_ff             <= pos_in;
      val_ff             <= val_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
      rsp_status_ff      <= rsp_status_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = $signed(rsp_read_value_ff);
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_status      = rsp_status_ff;

   // the count never passes the list size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // an accepted transaction either keeps the engine busy or answers next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted transaction neither busy nor answered");

   // the RAM is written only while working or on an accepted transaction
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (busy || accept))
      else $error("RAM write while idle");

   // a read answers in the cycle after its data comes back
   a_read_answer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (rsp_valid && !busy))
      else $error("read did not answer");

endmodule
`default_nettype wire

/* tb/positional_list_engine_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_test: self-checking bench for the positional list
// Drives append, insert, remove, read, clear and undefined-code transactions into the engine,
// mirrors the list in a local model and compares every response field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module positional_list_engine_test;
   import plist_pkg::*;

   localparam int unsigned LIST_CAPACITY = 256;
   // longest single transaction is an insert at the front of a nearly full list
   localparam int unsigned TAIL_CYCLES   = LIST_CAPACITY + 50;
   localparam longint      TIMEOUT_NS    = 10_000_000;

   // command codes the engine does not define; it must leave the list alone
   localparam cmd_type CMD_SPARE_5 = 3'd5;
   localparam cmd_type CMD_SPARE_6 = 3'd6;
   localparam cmd_type CMD_SPARE_7 = 3'd7;

   localparam logic [POS_W-1:0]  POS_MAX = '1;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   typedef enum int unsigned {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_type;

   typedef struct {
      logic signed [31:0] read_value;
      logic [POS_W-1:0]   entry_count;
      status_type         status;
      longint unsigned    accept_stamp;
   } list_result_type;

   logic                      clock;
   logic                      reset          = 1'b1;
   logic                      start          = 1'b0;
   logic                      busy;
   cmd_type                   req_command    = CMD_APPEND;
   logic [POS_W-1:0]          req_position   = '0;
   logic signed [31:0]        req_item_value = '0;
   logic                      rsp_valid;
   logic signed [31:0]        rsp_read_value;
   logic [POS_W-1:0]          rsp_entry_count;
   logic [STATUS_W-1:0]       rsp_status;

   // local mirror of the list contents and count
   logic signed [31:0]        model_entries [LIST_CAPACITY];
   int unsigned               model_count = 0;

   // predictions in acceptance order, popped as responses arrive
   list_result_type           expected_results [$];

   cmd_type                   spare_cmds [3] = '{CMD_SPARE_5, CMD_SPARE_6, CMD_SPARE_7};
   int unsigned               sender_idle_pct = 0;
   int                        error_count     = 0;

   positional_list_engine #(
      .CAPACITY(LIST_CAPACITY)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_entry_count(rsp_entry_count),
      .rsp_status     (rsp_status)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one accepted command to the mirror and return the response it
   // must produce. Insert past the count lands at the end; out-of-range and
   // empty-list accesses leave everything untouched.
   function automatic list_result_type apply_list_command(input cmd_type cmd,
         input logic [POS_W-1:0] pos, input logic signed [31:0] val);
      list_result_type res;
      int unsigned     slot;
      res.read_value   = '0;
      res.status       = ST_OK;
      res.accept_stamp = 0;
      case (cmd)
         CMD_APPEND, CMD_INSERT: begin
            if (model_count >= LIST_CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               slot = (cmd == CMD_INSERT && pos < model_count) ? pos : model_count;
               // shift the tail up one place to open the slot
               for (int unsigned i = model_count; i > slot; i--) begin
                  model_entries[i] = model_entries[i - 1];
               end
               model_entries[slot] = val;
               model_count++;
            end
         end
         CMD_REMOVE, CMD_READ: begin
            if (model_count == 0) begin
               res.status = ST_EMPTY;
            end else if (pos >= model_count) begin
               res.status = ST_RANGE;
            end else if (cmd == CMD_READ) begin
               res.read_value = model_entries[pos];
            end else begin
               // close the gap by shifting the tail down one place
               for (int unsigned i = pos; i + 1 < model_count; i++) begin
                  model_entries[i] = model_entries[i + 1];
               end
               model_count--;
            end
         end
         CMD_CLEAR: begin
            model_count = 0;
         end
         default: begin
         end
      endcase
      res.entry_count = POS_W'(model_count);
      return res;
   endfunction

   // Present one transaction, hold it until the engine takes it, record the
   // prediction, then idle the request side at the current rate. Start is
   // left high when the next transaction follows back to back.
   task automatic send_list_command(input cmd_type cmd, input logic [POS_W-1:0] pos,
         input logic signed [31:0] val);
      list_result_type res;
      start          <= 1'b1;
      req_command    <= cmd;
      req_position   <= pos;
      req_item_value <= val;
      // busy is read before the edge's updates land, so this is the
      // value the engine itself sampled at this edge
      do @(posedge clock); while (busy !== 1'b0);
      res = apply_list_command(cmd, pos, val);
      res.accept_stamp = $time;
      expected_results.push_back(res);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   // Drop start and wait until every outstanding response has been checked.
   // The queue is sampled at the falling edge, away from the checker's edge.
   task automatic drain_list_results();
      if (start) begin
         start <= 1'b0;
      end
      do @(negedge clock); while (expected_results.size() != 0);
      @(posedge clock);
   endtask

   // Mostly legal positions, with the boundaries and far out-of-range
   // indexes mixed in.
   function automatic logic [POS_W-1:0] pick_position();
      int unsigned r;
      r = $urandom_range(9);
      case (r)
         5:       return '0;
         6:       return POS_W'(model_count);
         7:       return (model_count == 0) ? '0 : POS_W'(model_count - 1);
         8, 9:    return POS_W'($urandom_range(POS_MAX));
         default: return POS_W'($urandom_range(model_count));
      endcase
   endfunction

   function automatic logic signed [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(15);
      case (r)
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic check_field(input string field_name, input logic [31:0] want_v,
         input logic [31:0] got_v);
      if (want_v !== got_v) begin
         error_count++;
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field_name, want_v, got_v);
      end
   endtask

   // Response checker: every strobed response must match the oldest
   // prediction. A prediction stamped at this very edge cannot have a
   // response yet, so it does not count as outstanding.
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0 || expected_results[0].accept_stamp >= $time) begin
            error_count++;
            $error("response strobed with no transaction outstanding");
         end else begin
            want = expected_results.pop_front();
            check_field("rsp_read_value", want.read_value, rsp_read_value);
            check_field("rsp_entry_count", want.entry_count, rsp_entry_count);
            check_field("rsp_status", want.status, rsp_status);
         end
      end
   end

   // Empty-list corner cases and the undefined command codes.
   task automatic test_empty_list();
      sender_idle_pct = 0;
      send_list_command(CMD_READ, '0, '0);
      send_list_command(CMD_REMOVE, '0, '0);
      send_list_command(CMD_READ, POS_MAX, VAL_MAX);
      send_list_command(CMD_REMOVE, POS_MAX, VAL_MIN);
      send_list_command(CMD_CLEAR, '0, '0);
      foreach (spare_cmds[k]) begin
         send_list_command(spare_cmds[k], POS_W'($urandom_range(POS_MAX)), $urandom);
      end
   endtask

   // Hand-built list exercising every command and the edit boundaries.
   task automatic test_directed_edits();
      sender_idle_pct = 69;
      send_list_command(CMD_APPEND, POS_MAX, VAL_MAX);
      send_list_command(CMD_APPEND, '0, VAL_MIN);
      send_list_command(CMD_INSERT, '0, -32'sd1);          // front insert
      send_list_command(CMD_INSERT, POS_MAX, '0);          // past count: appends
      send_list_command(CMD_INSERT, POS_W'(2), 32'sd1);    // middle insert
      send_list_command(CMD_READ, '0, '0);
      send_list_command(CMD_READ, POS_W'(2), '0);
      send_list_command(CMD_READ, POS_W'(4), '0);
      send_list_command(CMD_READ, POS_W'(5), '0);          // at count: out of range
      send_list_command(CMD_REMOVE, POS_W'(5), '0);
      send_list_command(CMD_REMOVE, '0, '0);               // drop the head
      send_list_command(CMD_REMOVE, POS_W'(3), '0);        // drop the tail
      send_list_command(CMD_REMOVE, POS_W'(1), '0);        // drop from the middle
      send_list_command(CMD_READ, POS_W'(1), '0);
      send_list_command(CMD_READ, POS_MAX, '0);
      send_list_command(CMD_CLEAR, POS_MAX, VAL_MAX);
      send_list_command(CMD_READ, '0, '0);
   endtask

   // Fill the list with random content, then push on the full boundary.
   task automatic test_fill_to_capacity();
      sender_idle_pct = 9;
      while (model_count < LIST_CAPACITY) begin
         if ($urandom_range(3) == 0) begin
            send_list_command(CMD_INSERT, pick_position(), pick_value());
         end else begin
            send_list_command(CMD_APPEND, POS_W'($urandom_range(POS_MAX)), pick_value());
         end
      end
      send_list_command(CMD_APPEND, '0, pick_value());
      send_list_command(CMD_INSERT, '0, pick_value());
      send_list_command(CMD_INSERT, POS_MAX, pick_value());
      send_list_command(CMD_READ, POS_W'(LIST_CAPACITY - 1), '0);
      send_list_command(CMD_READ, POS_W'(LIST_CAPACITY), '0);
      send_list_command(CMD_REMOVE, '0, '0);               // full-length shift down
      send_list_command(CMD_INSERT, '0, pick_value());     // full-length shift up
      send_list_command(CMD_REMOVE, POS_W'(LIST_CAPACITY - 1), '0);
      send_list_command(CMD_READ, pick_position(), '0);
   endtask

   // One random transaction; the trend biases the list toward growing,
   // shrinking or holding steady so the count sweeps its whole range.
   task automatic send_random_command(input trend_type trend);
      int unsigned roll;
      int unsigned add_pct;
      int unsigned drop_pct;
      cmd_type     cmd;
      add_pct  = (trend == TREND_GROW) ? 70 : (trend == TREND_SHRINK) ? 20 : 45;
      drop_pct = (trend == TREND_GROW) ? 10 : (trend == TREND_SHRINK) ? 55 : 25;
      roll = $urandom_range(99);
      if (roll < add_pct) begin
         cmd = $urandom_range(1) ? CMD_APPEND : CMD_INSERT;
      end else if (roll < add_pct + drop_pct) begin
         cmd = CMD_REMOVE;
      end else if (roll < 96) begin
         cmd = CMD_READ;
      end else if (roll < 99) begin
         cmd = spare_cmds[$urandom_range(2)];
      end else begin
         cmd = CMD_CLEAR;
      end
      send_list_command(cmd, pick_position(), pick_value());
   endtask

   // Random traffic in three request-side idle phases; the middle phase
   // stops once to let every response drain before resuming.
   task automatic test_random_traffic();
      int unsigned phase_idle [3] = '{0, 69, 9};
      trend_type   trend;
      trend = TREND_MIXED;
      foreach (phase_idle[p]) begin
         sender_idle_pct = phase_idle[p];
         for (int n = 0; n < 100; n++) begin
            if (n % 20 == 0) begin
               trend = trend_type'($urandom_range(2));
            end
            if (p == 1 && n == 50) begin
               drain_list_results();
            end
            send_random_command(trend);
         end
      end
   endtask

   initial begin
      // hold reset at the start, then release it
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_directed_edits();
      test_fill_to_capacity();
      test_random_traffic();
      drain_list_results();
      // watch for stray strobes after the last response
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog: stop a hung run
   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/plist_pkg.sv
rtl/core/plist_ram.sv
rtl/core/positional_list_engine.sv
tb/positional_list_engine_test.sv
